// File: src/wsd_pkg.sv
// Shared types and constants of the WebSocket frame deframer.
package wsd_pkg;

   // parser phases
   localparam logic [2:0] PH_HDR0    = 3'd0;
   localparam logic [2:0] PH_HDR1    = 3'd1;
   localparam logic [2:0] PH_EXTLEN  = 3'd2;
   localparam logic [2:0] PH_KEY     = 3'd3;
   localparam logic [2:0] PH_PAYLOAD = 3'd4;

   localparam logic [6:0] LEN_CODE_16 = 7'd126;
   localparam logic [6:0] LEN_CODE_64 = 7'd127;
   localparam logic [3:0] OP_CONT     = 4'h0;
   localparam logic [3:0] EXT_BYTES_16 = 4'd2;
   localparam logic [3:0] EXT_BYTES_64 = 4'd8;
   localparam logic [3:0] KEY_BYTES    = 4'd4;

   localparam int QUEUE_DEPTH = 4;

   typedef struct packed {
      logic       length_error;
      logic [3:0] message_opcode;
      logic       end_of_message;
      logic       has_data;
      logic [7:0] payload_byte;
   } result_type;

endpackage

// File: src/wsd_parser.sv
// Front end: header parser, length check and payload unmasking, one byte per cycle.
module wsd_parser #(
   parameter int LENGTH_BITS = 64
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_wr_en,
   input  logic [30:0]         csr_wr_data,
   input  logic                in_valid,
   input  logic [7:0]          in_byte,
   output logic                res_valid,
   output wsd_pkg::result_type res
);
   import wsd_pkg::*;

   localparam int CMP_W = (LENGTH_BITS > 31) ? LENGTH_BITS : 31;

   logic [30:0]            max_len_ff;
   logic [2:0]             phase_ff, phase_in;
   logic                   final_ff, final_in;
   logic                   masked_ff, masked_in;
   logic [3:0]             left_ff, left_in;
   logic [LENGTH_BITS-1:0] rem_ff, rem_in;
   logic [31:0]            key_ff, key_in;
   logic [1:0]             pos_ff, pos_in;
   logic [3:0]             op_ff, op_in;
   logic                   stopped_ff, stopped_in;

   logic                   hdr_done;
   logic                   too_long;
   logic [LENGTH_BITS-1:0] len_val;
   logic [7:0]             key_byte;

   always_comb begin
      phase_in   = phase_ff;
      final_in   = final_ff;
      masked_in  = masked_ff;
      left_in    = left_ff;
      rem_in     = rem_ff;
      key_in     = key_ff;
      pos_in     = pos_ff;
      op_in      = op_ff;
      stopped_in = stopped_ff;
      hdr_done   = 1'b0;
      too_long   = 1'b0;
      len_val    = rem_ff;
      res_valid  = 1'b0;
      res        = '0;
      res.message_opcode = op_ff;

      case (pos_ff)
         2'd0:    key_byte = key_ff[31:24];
         2'd1:    key_byte = key_ff[23:16];
         2'd2:    key_byte = key_ff[15:8];
         default: key_byte = key_ff[7:0];
      endcase

      if (in_valid && !stopped_ff) begin
         case (phase_ff)
            PH_HDR0: begin
               final_in = in_byte[7];
               if (in_byte[3:0] != OP_CONT) op_in = in_byte[3:0];
               phase_in = PH_HDR1;
            end
            PH_HDR1: begin
               masked_in = in_byte[7];
               if (in_byte[6:0] == LEN_CODE_16 || in_byte[6:0] == LEN_CODE_64) begin
                  left_in  = (in_byte[6:0] == LEN_CODE_64) ? EXT_BYTES_64 : EXT_BYTES_16;
                  rem_in   = '0;
                  phase_in = PH_EXTLEN;
               end else begin
                  len_val = LENGTH_BITS'(in_byte[6:0]);
                  rem_in  = len_val;
                  if (in_byte[7]) begin
                     left_in  = KEY_BYTES;
                     phase_in = PH_KEY;
                  end else begin
                     hdr_done = 1'b1;
                  end
               end
            end
            PH_EXTLEN: begin
               // saturate once the value would shift out of range
               if (|rem_ff[LENGTH_BITS-1 -: 8]) len_val = '1;
               else                             len_val = {rem_ff[LENGTH_BITS-9:0], in_byte};
               rem_in  = len_val;
               left_in = left_ff - 4'd1;
               if (left_ff == 4'd1) begin
                  if (masked_ff) begin
                     left_in  = KEY_BYTES;
                     phase_in = PH_KEY;
                  end else begin
                     hdr_done = 1'b1;
                  end
               end
            end
            PH_KEY: begin
               key_in  = {key_ff[23:0], in_byte};
               left_in = left_ff - 4'd1;
               if (left_ff == 4'd1) hdr_done = 1'b1;
            end
            PH_PAYLOAD: begin
               pos_in = pos_ff + 2'd1;
               if (rem_ff != '0) rem_in = rem_ff - LENGTH_BITS'(1);
               res_valid        = 1'b1;
               res.has_data     = 1'b1;
               res.payload_byte = masked_ff ? (in_byte ^ key_byte) : in_byte;
               if (rem_in == '0) begin
                  res.end_of_message = final_ff;
                  phase_in           = PH_HDR0;
               end
            end
            default: phase_in = PH_HDR0;
         endcase

         if (hdr_done) begin
            pos_in   = 2'd0;
            left_in  = 4'd0;
            too_long = (max_len_ff != '0) && (CMP_W'(len_val) > CMP_W'(max_len_ff));
            if (too_long) begin
               stopped_in       = 1'b1;
               phase_in         = PH_HDR0;
               res_valid        = 1'b1;
               res.length_error = 1'b1;
            end else if (len_val == '0) begin
               phase_in = PH_HDR0;
               if (final_ff) begin
                  res_valid          = 1'b1;
                  res.end_of_message = 1'b1;
               end
            end else begin
               phase_in = PH_PAYLOAD;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff <= '0;
         phase_ff   <= PH_HDR0;
         op_ff      <= '0;
         stopped_ff <= 1'b0;
      end else begin
         if (csr_wr_en) max_len_ff <= csr_wr_data;
         phase_ff   <= phase_in;
         op_ff      <= op_in;
         stopped_ff <= stopped_in;
      end
   end

   always_ff @(posedge clock) begin
      final_ff  <= final_in;
      masked_ff <= masked_in;
      left_ff   <= left_in;
      rem_ff    <= rem_in;
      key_ff    <= key_in;
      pos_ff    <= pos_in;
   end

endmodule

// File: src/wsd_queue.sv
// Back end: small result queue that drives the output channel.
module wsd_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  wsd_pkg::result_type push_data,
   output logic                not_full,
   output logic                out_valid,
   input  logic                out_ready,
   output wsd_pkg::result_type out_data
);
   import wsd_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   result_type       entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             pop;

   assign not_full  = (count_ff != CNT_W'(QUEUE_DEPTH));
   assign out_valid = (count_ff != '0);
   assign out_data  = entry_ff[rd_ptr_ff];
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop)      count_in = count_ff + CNT_W'(1);
      else if (pop && !push) count_in = count_ff - CNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) entry_ff[wr_ptr_ff] <= push_data;
   end

endmodule

// File: src/websocket_frame_deframer.sv
// WebSocket frame deframer (receive side): top level.
//
// Usage: frame stream bytes enter on req_* one word per cycle while
// req_tready is high. The parser reads the header (FIN/opcode, mask bit and
// length, extended length, masking key), then emits each payload byte
// unmasked on rsp_*. A frame with FIN marks its last word with rsp_tlast;
// a zero-length FIN frame gives a marker word with has_data low. A frame
// longer than the nonzero limit in csr_wr_data gives one error word, and
// all later bytes are dropped until reset. Each result is written into the
// queue before it appears on rsp_*. Throughput: one byte per cycle while
// the queue has room; the parser updates its state once per byte, and a
// four-word queue separates it from the output side. Reset (synchronous)
// clears the limit, the stop flag, the parser phase, the opcode and the
// queue. When the receiver stalls, the queue fills and req_tready drops
// once four results are waiting; header bytes still need a free slot.
module websocket_frame_deframer #(
   parameter int LENGTH_BITS = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [30:0] csr_wr_data,   // max_frame_length
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,     // rx_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,     // payload_byte
   output logic [5:0]  rsp_tuser,     // has_data, message_opcode[3:0], length_error
   output logic        rsp_tlast      // end_of_message
);
   import wsd_pkg::*;

   logic       accept;
   logic       res_valid;
   result_type res;
   result_type head;

   assign accept = req_tvalid && req_tready;

   wsd_parser #(.LENGTH_BITS(LENGTH_BITS)) u_parser (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .in_valid    (accept),
      .in_byte     (req_tdata),
      .res_valid   (res_valid),
      .res         (res)
   );

   wsd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (res_valid),
      .push_data (res),
      .not_full  (req_tready),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (head)
   );

   assign rsp_tdata = head.payload_byte;
   assign rsp_tuser = {head.length_error, head.message_opcode, head.has_data};
   assign rsp_tlast = head.end_of_message;

endmodule

// File: src/wsd_checker.sv
// Port-level checks for the deframer, bound to the top level.
module wsd_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic [5:0] rsp_tuser,
   input logic       rsp_tlast
);

   // no data word is left over across reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("rsp_tvalid high right after reset");

   // marker and error words carry a zero byte
   a_nodata_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata == 8'd0)
      else $error("nonzero payload on a word without data");

   // an error word is neither data nor end of message
   a_error_form: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[5] |-> !rsp_tuser[0] && !rsp_tlast)
      else $error("error word carries data or end of message");

   a_valid_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("rsp_tvalid dropped while stalled");

   a_data_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=>
         $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("rsp word changed while stalled");

endmodule

bind websocket_frame_deframer wsd_checker u_wsd_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

// File: verif/websocket_frame_deframer_tb.sv
// Self-checking testbench for the WebSocket frame deframer: directed frames, random frames.
`timescale 1ns / 100ps

module websocket_frame_deframer_tb;
   import wsd_pkg::*;

   localparam int LEN_BITS = 64;
   localparam logic [63:0] LEN_MASK = {64{1'b1}} >> (64 - LEN_BITS);

   typedef enum int {ENC_SHORT, ENC_16, ENC_64} len_enc_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        csr_wr_en;
   logic [30:0] csr_wr_data;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [7:0]  rsp_tdata;
   logic [5:0]  rsp_tuser;   // has_data, message_opcode[3:0], length_error
   logic        rsp_tlast;   // end_of_message

   // parser shadow
   logic [2:0]  parse_phase;
   logic        fin_flag;
   logic        is_masked;
   logic [6:0]  len_code;
   logic [3:0]  hdr_left;
   logic [63:0] frame_len;
   logic [31:0] frame_key;
   logic [1:0]  key_pos;
   logic [3:0]  msg_opcode;
   logic        halted;
   logic [30:0] frame_limit;

   result_type  deframed_q[$];
   int          error_count = 0;
   int          words_sent = 0;
   int          burst_left = 0;
   logic        sender_gaps = 1'b1;
   int          hold_request = 0;
   int          hold_left = 0;
   int          pattern_left = 0;
   int          ready_pct = 100;

   websocket_frame_deframer #(.LENGTH_BITS(LEN_BITS)) dut (
      .clock(clock),
      .reset(reset),
      .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .rsp_tlast(rsp_tlast)
   );

   always #5 clock = ~clock;

   initial begin
      #2000000;
      $display("TEST FAILED");
      $finish;
   end

   function void queue_result(input logic [7:0] data, input logic has, input logic eom,
                              input logic err);
      result_type r;
      r.payload_byte   = data;
      r.has_data       = has;
      r.end_of_message = eom;
      r.message_opcode = msg_opcode;
      r.length_error   = err;
      deframed_q.push_back(r);
   endfunction

   function void finish_header();
      key_pos  = 2'd0;
      hdr_left = 4'd0;
      if (frame_limit != 31'd0 && frame_len > {33'd0, frame_limit}) begin
         halted      = 1'b1;
         parse_phase = PH_HDR0;
         queue_result(8'h00, 1'b0, 1'b0, 1'b1);
      end else if (frame_len == 64'd0) begin
         parse_phase = PH_HDR0;
         if (fin_flag) queue_result(8'h00, 1'b0, 1'b1, 1'b0);
      end else begin
         parse_phase = PH_PAYLOAD;
      end
   endfunction

   function void deframe_byte(input logic [7:0] b);
      logic [7:0] d;
      logic       eom;
      if (halted) return;
      case (parse_phase)
         PH_HDR0: begin
            fin_flag = b[7];
            if (b[3:0] != OP_CONT) msg_opcode = b[3:0];
            parse_phase = PH_HDR1;
         end
         PH_HDR1: begin
            is_masked = b[7];
            len_code  = b[6:0];
            frame_len = 64'd0;
            frame_key = 32'd0;
            if (len_code == LEN_CODE_16 || len_code == LEN_CODE_64) begin
               hdr_left    = (len_code == LEN_CODE_16) ? EXT_BYTES_16 : EXT_BYTES_64;
               parse_phase = PH_EXTLEN;
            end else begin
               frame_len = {57'd0, len_code};
               if (is_masked) begin
                  hdr_left    = KEY_BYTES;
                  parse_phase = PH_KEY;
               end else begin
                  finish_header();
               end
            end
         end
         PH_EXTLEN: begin
            // saturate once the length no longer fits
            if (frame_len > (LEN_MASK >> 8)) frame_len = LEN_MASK;
            else frame_len = ((frame_len << 8) | {56'd0, b}) & LEN_MASK;
            hdr_left = hdr_left - 4'd1;
            if (hdr_left == 4'd0) begin
               if (is_masked) begin
                  hdr_left    = KEY_BYTES;
                  parse_phase = PH_KEY;
               end else begin
                  finish_header();
               end
            end
         end
         PH_KEY: begin
            frame_key = {frame_key[23:0], b};
            hdr_left  = hdr_left - 4'd1;
            if (hdr_left == 4'd0) finish_header();
         end
         PH_PAYLOAD: begin
            d   = b;
            eom = 1'b0;
            // first key byte received sits in the top bits
            if (is_masked) d = d ^ frame_key[8 * (3 - int'(key_pos)) +: 8];
            key_pos = key_pos + 2'd1;
            if (frame_len != 64'd0) frame_len = frame_len - 64'd1;
            if (frame_len == 64'd0) begin
               eom         = fin_flag;
               parse_phase = PH_HDR0;
            end
            queue_result(d, 1'b1, eom, 1'b0);
         end
         default: parse_phase = PH_HDR0;
      endcase
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("%0t mismatch %s: got %0h want %0h", $time, what, got, want);
      error_count++;
   endtask

   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (deframed_q.size() == 0) begin
            report_mismatch("unexpected word", {50'd0, rsp_tuser, rsp_tdata}, 64'd0);
         end else begin
            want = deframed_q.pop_front();
            if (rsp_tdata !== want.payload_byte)
               report_mismatch("payload_byte", 64'(rsp_tdata), 64'(want.payload_byte));
            if (rsp_tuser[0] !== want.has_data)
               report_mismatch("has_data", 64'(rsp_tuser[0]), 64'(want.has_data));
            if (rsp_tuser[4:1] !== want.message_opcode)
               report_mismatch("message_opcode", 64'(rsp_tuser[4:1]),
                               64'(want.message_opcode));
            if (rsp_tuser[5] !== want.length_error)
               report_mismatch("length_error", 64'(rsp_tuser[5]), 64'(want.length_error));
            if (rsp_tlast !== want.end_of_message)
               report_mismatch("end_of_message", 64'(rsp_tlast), 64'(want.end_of_message));
         end
      end
   end

   // receiver: random ready pattern, plus long hold-offs on request
   always @(negedge clock) begin
      if (hold_request != 0) begin
         hold_left    = hold_request;
         hold_request = 0;
      end
      if (hold_left != 0) begin
         rsp_tready <= 1'b0;
         hold_left--;
      end else begin
         if (pattern_left == 0) begin
            pattern_left = $urandom_range(30, 150);
            case ($urandom_range(0, 3))
               0: ready_pct = 100;
               1: ready_pct = 75;
               2: ready_pct = 40;
               default: ready_pct = 15;
            endcase
         end
         pattern_left--;
         rsp_tready <= ($urandom_range(0, 99) < ready_pct);
      end
   end

   task automatic send_word(input logic [7:0] value);
      int gap;
      if (sender_gaps && burst_left == 0) begin
         gap        = $urandom_range(1, 6);
         burst_left = $urandom_range(1, 40);
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      if (burst_left > 0) burst_left--;
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      deframe_byte(value);
      words_sent++;
      @(negedge clock);
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (deframed_q.size() != 0) @(negedge clock);
      repeat (10) @(negedge clock);
   endtask

   task automatic write_limit(input logic [30:0] value);
      wait_idle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      frame_limit = value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // payload of huge frames is cut short; only used where the block stops
   task automatic send_frame(input logic fin, input logic [3:0] op, input logic [2:0] rsv,
                             input logic masked, input logic [63:0] len,
                             input len_enc_type enc);
      logic [6:0]  code;
      logic [31:0] key;
      longint      n_pay;
      key = $urandom;
      case (enc)
         ENC_16:  code = LEN_CODE_16;
         ENC_64:  code = LEN_CODE_64;
         default: code = len[6:0];
      endcase
      send_word({fin, rsv, op});
      send_word({masked, code});
      if (enc == ENC_16) for (int i = 1; i >= 0; i--) send_word(len[8 * i +: 8]);
      if (enc == ENC_64) for (int i = 7; i >= 0; i--) send_word(len[8 * i +: 8]);
      if (masked) for (int i = 3; i >= 0; i--) send_word(key[8 * i +: 8]);
      n_pay = (len > 64'd4096) ? 16 : longint'(len);
      for (longint i = 0; i < n_pay; i++) send_word(8'($urandom_range(0, 255)));
   endtask

   task automatic send_random_frame();
      int          pick;
      logic [63:0] len;
      len_enc_type enc;
      logic [3:0]  op;
      logic [2:0]  rsv;
      logic        fin;
      logic        masked;
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
         len = 64'($urandom_range(0, 20));
         enc = ENC_SHORT;
      end else if (pick < 80) begin
         len = 64'($urandom_range(21, 125));
         enc = ENC_SHORT;
      end else if (pick < 95) begin
         len = 64'($urandom_range(0, 150));
         enc = ENC_16;
      end else begin
         len = 64'($urandom_range(0, 150));
         enc = ENC_64;
      end
      // mostly data/control opcodes, sometimes reserved ones
      if ($urandom_range(0, 9) < 7) begin
         op[3]   = 1'($urandom_range(0, 1));
         op[2]   = 1'b0;
         op[1:0] = 2'($urandom_range(0, 2));
      end else begin
         op = 4'($urandom_range(0, 15));
      end
      rsv    = ($urandom_range(0, 7) == 0) ? 3'($urandom_range(0, 7)) : 3'd0;
      fin    = ($urandom_range(0, 3) != 0);
      masked = 1'($urandom_range(0, 1));
      send_frame(fin, op, rsv, masked, len, enc);
   endtask

   task automatic test_basic_frames();
      write_limit(31'd0);
      send_frame(1'b1, 4'h1, 3'b000, 1'b0, 64'd1, ENC_SHORT);
      send_frame(1'b1, 4'h2, 3'b000, 1'b1, 64'd5, ENC_SHORT);
      send_frame(1'b1, 4'h9, 3'b000, 1'b0, 64'd0, ENC_SHORT);    // marker only
      send_frame(1'b0, 4'h1, 3'b000, 1'b1, 64'd0, ENC_SHORT);    // no word
      send_frame(1'b0, OP_CONT, 3'b000, 1'b1, 64'd3, ENC_SHORT); // keeps opcode
      send_frame(1'b1, OP_CONT, 3'b000, 1'b0, 64'd2, ENC_SHORT);
      send_frame(1'b1, 4'hF, 3'b111, 1'b1, 64'd125, ENC_SHORT);
   endtask

   task automatic test_extended_lengths();
      send_frame(1'b1, 4'h2, 3'b000, 1'b0, 64'd3, ENC_16);
      send_frame(1'b1, 4'h1, 3'b000, 1'b1, 64'd20, ENC_16);
      send_frame(1'b1, 4'hA, 3'b000, 1'b0, 64'd5, ENC_64);
      send_frame(1'b1, 4'h2, 3'b000, 1'b1, 64'd0, ENC_64);
      send_frame(1'b0, 4'h2, 3'b000, 1'b1, 64'd0, ENC_16);
   endtask

   task automatic test_length_limits();
      write_limit(31'd1);
      send_frame(1'b1, 4'h1, 3'b000, 1'b0, 64'd1, ENC_SHORT);
      send_frame(1'b1, 4'h1, 3'b000, 1'b1, 64'd0, ENC_SHORT);
      write_limit(31'd40);
      send_frame(1'b1, 4'h2, 3'b000, 1'b1, 64'd40, ENC_16);     // equal to limit
      write_limit(31'h7FFF_FFFF);
      send_frame(1'b1, 4'h2, 3'b000, 1'b1, 64'd30, ENC_16);
   endtask

   task automatic test_backpressure();
      write_limit(31'd0);
      sender_gaps  = 1'b0;
      hold_request = 80;
      send_frame(1'b1, 4'h2, 3'b000, 1'b1, 64'd20, ENC_SHORT);
      sender_gaps = 1'b1;
   endtask

   task automatic test_random_frames();
      int stop_at;
      for (int seg = 0; seg < 3; seg++) begin
         case (seg)
            0: write_limit(31'd0);
            1: write_limit(31'h7FFF_FFFF);
            default: write_limit(31'd300);
         endcase
         stop_at = words_sent + 30;
         while (words_sent < stop_at) send_random_frame();
      end
   endtask

   // must run last: the block ignores everything after the error until reset
   task automatic test_length_error();
      write_limit(31'h7FFF_FFFF);
      send_frame(1'b1, 4'h2, 3'b000, 1'b1, 64'h0000_0000_8000_0000, ENC_64);
      repeat (20) send_word(8'($urandom_range(0, 255)));
   endtask

   initial begin
      reset       = 1'b1;
      csr_wr_en   = 1'b0;
      csr_wr_data = 31'd0;
      req_tvalid  = 1'b0;
      req_tdata   = 8'h00;
      rsp_tready  = 1'b0;
      parse_phase = PH_HDR0;
      fin_flag    = 1'b0;
      is_masked   = 1'b0;
      len_code    = 7'd0;
      hdr_left    = 4'd0;
      frame_len   = 64'd0;
      frame_key   = 32'd0;
      key_pos     = 2'd0;
      msg_opcode  = OP_CONT;
      halted      = 1'b0;
      frame_limit = 31'd0;
      repeat (6) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_basic_frames();
      test_extended_lengths();
      test_length_limits();
      test_backpressure();
      test_random_frames();
      test_length_error();

      wait_idle();
      if (error_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

// File: filelist.f
src/wsd_pkg.sv
src/wsd_parser.sv
src/wsd_queue.sv
src/websocket_frame_deframer.sv
src/wsd_checker.sv
verif/websocket_frame_deframer_tb.sv
